// File: rtl/depq_pkg.sv
package depq_pkg;

   localparam int VALUE_W = 32;

   typedef logic [1:0] opcode_type;
   typedef logic signed [VALUE_W-1:0] value_type;

   localparam opcode_type OP_INSERT  = 2'd0;
   localparam opcode_type OP_DEL_MAX = 2'd1;
   localparam opcode_type OP_DEL_MIN = 2'd2;

   // control from the sequencer to the shared compare unit
   typedef struct packed {
      logic take;      // a read value is presented this cycle
      logic first;     // first entry of a pass: take it unconditionally
      logic want_max;  // 1 greatest, 0 least
   } scan_ctrl_type;

endpackage

// File: rtl/depq_extreme.sv
module depq_extreme
   import depq_pkg::*;
#(
   parameter int IDX_W = 4
) (
   input  logic              clock,
   input  scan_ctrl_type     ctrl,
   input  value_type         data,
   input  logic [IDX_W-1:0]  idx,
   output value_type         best,
   output logic [IDX_W-1:0]  best_idx
);

   value_type          best_ff;
   value_type          best_in;
   logic [IDX_W-1:0]   best_idx_ff;
   logic [IDX_W-1:0]   best_idx_in;
   value_type          cmp_a;
   value_type          cmp_b;
   logic               better;

   // single signed comparator, operands swapped for min
   always_comb begin
      cmp_a       = ctrl.want_max ? data : best_ff;
      cmp_b       = ctrl.want_max ? best_ff : data;
      better      = cmp_a > cmp_b;
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      if (ctrl.take && (ctrl.first || better)) begin
         best_in     = data;
         best_idx_in = idx;
      end
   end

   always_ff @(posedge clock) begin
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
   end

   assign best     = best_ff;
   assign best_idx = best_idx_ff;

endmodule

// File: rtl/double_ended_priority_queue.sv
// Double-ended priority queue holding up to DEPTH signed 32-bit values in a
// single-port-read memory. Each transfer carries insert, delete-max or
// delete-min and yields exactly one result with the new count, greatest and
// least values (0 when empty), an empty flag and a flag for an insert refused
// because the store was full. One item at a time: one comparator walks the
// memory one entry per cycle, with one pass for the greatest and one for the
// least after an insert, a refused insert or a no-op on a non-empty store. A
// delete first makes one pass to find the entry to remove, then the same two
// passes unless it removed the last value. A delete or no-op on an empty
// store goes straight to the result.
// req_stall is high while an item is in progress; a finished result waits in
// the output register without blocking the next transfer.
module double_ended_priority_queue
   import depq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  opcode_type                       req_opcode,
   input  value_type                        req_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [$clog2(DEPTH+1)-1:0]       rsp_count,
   output value_type                        rsp_max_value,
   output value_type                        rsp_min_value,
   output logic                             rsp_is_empty,
   output logic                             rsp_dropped
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_FIND     = 3'd1;
   localparam logic [2:0] S_MOVE_RD  = 3'd2;
   localparam logic [2:0] S_MOVE_WR  = 3'd3;
   localparam logic [2:0] S_SCAN_MAX = 3'd4;
   localparam logic [2:0] S_SCAN_MIN = 3'd5;
   localparam logic [2:0] S_PUT      = 3'd6;

   value_type           mem [DEPTH];

   logic [2:0]          state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    addr_ff, addr_in;
   logic                pend_ff, pend_in;
   logic [IDX_W-1:0]    pidx_ff, pidx_in;
   opcode_type          op_ff, op_in;
   logic                drop_ff, drop_in;
   value_type           max_ff, max_in;
   value_type           min_ff, min_in;
   value_type           rd_data_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]    rsp_count_ff;
   value_type           rsp_max_ff, rsp_min_ff;
   logic                rsp_empty_ff, rsp_drop_ff;
   logic                rsp_load;

   logic                rd_en;
   logic [IDX_W-1:0]    rd_addr;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   value_type           wr_data;

   logic [CNT_W-1:0]    cnt_m1;
   logic                scanning;
   logic                scan_done;
   logic                accept;
   scan_ctrl_type       ctrl;
   value_type           best;
   logic [IDX_W-1:0]    best_idx;

   depq_extreme #(
      .IDX_W (IDX_W)
   ) u_extreme (
      .clock    (clock),
      .ctrl     (ctrl),
      .data     (rd_data_ff),
      .idx      (pidx_ff),
      .best     (best),
      .best_idx (best_idx)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign cnt_m1    = count_ff - CNT_W'(1);
   assign scanning  = (state_ff == S_FIND) || (state_ff == S_SCAN_MAX) ||
                      (state_ff == S_SCAN_MIN);
   assign scan_done = (addr_ff >= count_ff) && !pend_ff;
   assign rsp_load  = (state_ff == S_PUT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      ctrl.take     = scanning && pend_ff;
      ctrl.first    = (pidx_ff == '0);
      ctrl.want_max = (state_ff == S_SCAN_MAX) ||
                      ((state_ff == S_FIND) && (op_ff == OP_DEL_MAX));
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      addr_in  = '0;
      pend_in  = 1'b0;
      pidx_in  = pidx_ff;
      op_in    = op_ff;
      drop_in  = drop_ff;
      max_in   = max_ff;
      min_in   = min_ff;
      rd_en    = 1'b0;
      rd_addr  = addr_ff[IDX_W-1:0];
      wr_en    = 1'b0;
      wr_addr  = count_ff[IDX_W-1:0];
      wr_data  = req_value;

      if (scanning) begin
         if (addr_ff < count_ff) begin
            rd_en   = 1'b1;
            pend_in = 1'b1;
            pidx_in = addr_ff[IDX_W-1:0];
            addr_in = addr_ff + CNT_W'(1);
         end else if (pend_ff) begin
            addr_in = addr_ff;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in   = req_opcode;
               drop_in = 1'b0;
               priority if (req_opcode == OP_INSERT) begin
                  if (count_ff >= CNT_W'(DEPTH)) begin
                     drop_in  = 1'b1;
                     state_in = S_SCAN_MAX;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                     state_in = S_SCAN_MAX;
                  end
               end else if (count_ff == '0) begin
                  state_in = S_PUT;
               end else if ((req_opcode == OP_DEL_MAX) || (req_opcode == OP_DEL_MIN)) begin
                  state_in = S_FIND;
               end else begin
                  state_in = S_SCAN_MAX;
               end
            end
         end
         S_FIND: begin
            if (scan_done) begin
               state_in = S_MOVE_RD;
            end
         end
         S_MOVE_RD: begin
            rd_en    = 1'b1;
            rd_addr  = cnt_m1[IDX_W-1:0];
            state_in = S_MOVE_WR;
         end
         S_MOVE_WR: begin
            wr_en    = 1'b1;
            wr_addr  = best_idx;
            wr_data  = rd_data_ff;
            count_in = cnt_m1;
            state_in = (cnt_m1 == '0) ? S_PUT : S_SCAN_MAX;
         end
         S_SCAN_MAX: begin
            if (scan_done) begin
               max_in   = best;
               state_in = S_SCAN_MIN;
            end
         end
         S_SCAN_MIN: begin
            if (scan_done) begin
               min_in   = best;
               state_in = S_PUT;
            end
         end
         S_PUT: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         addr_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         addr_ff      <= addr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff <= pidx_in;
      op_ff   <= op_in;
      drop_ff <= drop_in;
      max_ff  <= max_in;
      min_ff  <= min_in;
      if (rsp_load) begin
         rsp_count_ff <= count_ff;
         rsp_empty_ff <= (count_ff == '0);
         rsp_drop_ff  <= drop_ff;
         rsp_max_ff   <= (count_ff == '0) ? value_type'(0) : max_ff;
         rsp_min_ff   <= (count_ff == '0) ? value_type'(0) : min_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_max_value = rsp_max_ff;
   assign rsp_min_value = rsp_min_ff;
   assign rsp_is_empty  = rsp_empty_ff;
   assign rsp_dropped   = rsp_drop_ff;

endmodule
